>>> rtl/lpg_pkg.sv
// ----------------------------------------------------------------------------
// lpg_pkg
// Shared types and constants of the line pixel generator: beat layouts,
// command codes, the normalised line descriptor and register map.
// ----------------------------------------------------------------------------
package lpg_pkg;

    // coordinate and colour widths
    localparam int COORD_BITS     = 12;
    localparam int COLOR_BITS     = 16;
    localparam int APB_DATA_BITS  = 32;
    localparam int APB_ADDR_BITS  = 3;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [COORD_BITS:0]   t_wide;
    typedef logic        [COORD_BITS-1:0] t_delta;
    typedef logic        [COORD_BITS:0]   t_err;
    typedef logic        [COLOR_BITS-1:0] t_color;

    localparam t_coord COORD_ONE = t_coord'(1);

    // command codes
    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    // register map (word index)
    localparam logic REG_DRAW_COLOR = 1'b0;
    localparam t_color DRAW_COLOR_RESET = t_color'(16'hFFFF);

    // input beat
    typedef struct packed {
        logic   cmd;
        t_coord start_x;
        t_coord start_y;
        t_coord end_x;
        t_coord end_y;
    } t_in_beat;

    // output beat
    typedef struct packed {
        t_coord pixel_x;
        t_coord pixel_y;
        t_color pixel_color;
        logic   last_pixel;
    } t_out_beat;

    // line with endpoints ordered along the major axis
    typedef struct packed {
        t_coord cur_x;
        t_coord cur_y;
        t_coord stop_x;
        t_coord stop_y;
        t_delta delta_major;
        t_delta delta_minor;
        logic   steep;
        logic   minor_down;
    } t_line;

    // status of the stepping stage
    typedef struct packed {
        logic produce;
        logic busy;
    } t_step_status;

endpackage

>>> rtl/lpg_setup.sv
// ----------------------------------------------------------------------------
// lpg_setup
// Normalises a start beat: absolute deltas, choice of major axis, endpoint
// order so the major coordinate rises, and direction of the minor axis.
// ----------------------------------------------------------------------------
module lpg_setup (
    input  lpg_pkg::t_in_beat i_beat,
    output lpg_pkg::t_line    o_line
);

    lpg_pkg::t_coord ax, ay, bx, by;
    lpg_pkg::t_coord first_x, first_y, last_x, last_y;
    lpg_pkg::t_wide  ax_e, ay_e, bx_e, by_e;
    lpg_pkg::t_wide  dx_w, dy_w;
    lpg_pkg::t_delta dx, dy;
    logic            x_a_gt, y_a_gt, steep, swap;

    // absolute deltas
    always_comb begin
        ax     = i_beat.start_x;
        ay     = i_beat.start_y;
        bx     = i_beat.end_x;
        by     = i_beat.end_y;
        ax_e   = lpg_pkg::t_wide'(ax);
        ay_e   = lpg_pkg::t_wide'(ay);
        bx_e   = lpg_pkg::t_wide'(bx);
        by_e   = lpg_pkg::t_wide'(by);
        x_a_gt = ax > bx;
        y_a_gt = ay > by;
        dx_w   = x_a_gt ? (ax_e - bx_e) : (bx_e - ax_e);
        dy_w   = y_a_gt ? (ay_e - by_e) : (by_e - ay_e);
        dx     = dx_w[lpg_pkg::COORD_BITS-1:0];
        dy     = dy_w[lpg_pkg::COORD_BITS-1:0];
    end

    // major axis and endpoint order
    always_comb begin
        steep   = dy > dx;
        swap    = steep ? y_a_gt : x_a_gt;
        first_x = swap ? bx : ax;
        first_y = swap ? by : ay;
        last_x  = swap ? ax : bx;
        last_y  = swap ? ay : by;

        o_line.cur_x       = first_x;
        o_line.cur_y       = first_y;
        o_line.stop_x      = last_x;
        o_line.stop_y      = last_y;
        o_line.delta_major = steep ? dy : dx;
        o_line.delta_minor = steep ? dx : dy;
        o_line.steep       = steep;
        o_line.minor_down  = steep ? (first_x > last_x) : (first_y > last_y);
    end

endmodule

>>> rtl/lpg_step.sv
// ----------------------------------------------------------------------------
// lpg_step
// Line state and one Bresenham step per beat: major advance, error update,
// clamped minor step and last-pixel detection.
// ----------------------------------------------------------------------------
module lpg_step (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  logic                  i_cmd,
    input  lpg_pkg::t_line        i_line,
    input  lpg_pkg::t_color       i_color,
    output lpg_pkg::t_out_beat    o_pixel,
    output lpg_pkg::t_step_status o_status
);

    // move one step toward the target, never past it
    function automatic lpg_pkg::t_coord move_toward(
        input lpg_pkg::t_coord c,
        input lpg_pkg::t_coord target,
        input logic            down
    );
        lpg_pkg::t_coord res;
        res = c;
        if (down) begin
            if (c > target) res = c - lpg_pkg::COORD_ONE;
        end else begin
            if (c < target) res = c + lpg_pkg::COORD_ONE;
        end
        return res;
    endfunction

    lpg_pkg::t_coord r_cur_x, r_cur_y, r_stop_x, r_stop_y;
    lpg_pkg::t_delta r_delta_major, r_delta_minor;
    lpg_pkg::t_err   r_error_acc;
    logic            r_steep, r_minor_down, r_busy;

    lpg_pkg::t_coord n_cur_x, n_cur_y, n_stop_x, n_stop_y;
    lpg_pkg::t_delta n_delta_major, n_delta_minor;
    lpg_pkg::t_err   n_error_acc;
    logic            n_steep, n_minor_down, n_busy;

    lpg_pkg::t_coord base_x, base_y;
    lpg_pkg::t_err   base_err, err_sum;
    logic            produce, step_minor, last;

    // pick starting point of this step
    always_comb begin
        produce       = (i_cmd == lpg_pkg::CMD_START) || r_busy;
        if (i_cmd == lpg_pkg::CMD_START) begin
            base_x        = i_line.cur_x;
            base_y        = i_line.cur_y;
            n_stop_x      = i_line.stop_x;
            n_stop_y      = i_line.stop_y;
            n_delta_major = i_line.delta_major;
            n_delta_minor = i_line.delta_minor;
            n_steep       = i_line.steep;
            n_minor_down  = i_line.minor_down;
            base_err      = '0;
        end else begin
            base_x        = r_steep ? r_cur_x : r_cur_x + lpg_pkg::COORD_ONE;
            base_y        = r_steep ? r_cur_y + lpg_pkg::COORD_ONE : r_cur_y;
            n_stop_x      = r_stop_x;
            n_stop_y      = r_stop_y;
            n_delta_major = r_delta_major;
            n_delta_minor = r_delta_minor;
            n_steep       = r_steep;
            n_minor_down  = r_minor_down;
            base_err      = r_error_acc;
        end
    end

    // error update, minor step and end test
    always_comb begin
        err_sum    = base_err + lpg_pkg::t_err'(n_delta_minor);
        step_minor = err_sum >= lpg_pkg::t_err'(n_delta_major);
        n_error_acc = step_minor ? err_sum - lpg_pkg::t_err'(n_delta_major) : err_sum;
        n_cur_x    = (step_minor && n_steep)
                   ? move_toward(base_x, n_stop_x, n_minor_down) : base_x;
        n_cur_y    = (step_minor && !n_steep)
                   ? move_toward(base_y, n_stop_y, n_minor_down) : base_y;
        last       = n_steep ? (n_cur_y >= n_stop_y) : (n_cur_x >= n_stop_x);
        n_busy     = !last;
    end

    // line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x       <= '0;
            r_cur_y       <= '0;
            r_stop_x      <= '0;
            r_stop_y      <= '0;
            r_delta_major <= '0;
            r_delta_minor <= '0;
            r_error_acc   <= '0;
            r_steep       <= 1'b0;
            r_minor_down  <= 1'b0;
            r_busy        <= 1'b0;
        end else if (i_fire && produce) begin
            r_cur_x       <= n_cur_x;
            r_cur_y       <= n_cur_y;
            r_stop_x      <= n_stop_x;
            r_stop_y      <= n_stop_y;
            r_delta_major <= n_delta_major;
            r_delta_minor <= n_delta_minor;
            r_error_acc   <= n_error_acc;
            r_steep       <= n_steep;
            r_minor_down  <= n_minor_down;
            r_busy        <= n_busy;
        end
    end

    // pixel and status
    always_comb begin
        o_pixel.pixel_x     = n_cur_x;
        o_pixel.pixel_y     = n_cur_y;
        o_pixel.pixel_color = i_color;
        o_pixel.last_pixel  = last;
        o_status.produce    = produce;
        o_status.busy       = r_busy;
    end

endmodule

>>> rtl/line_pixel_generator_unit.sv
// ----------------------------------------------------------------------------
// line_pixel_generator_unit
// Bresenham line drawer: turns start and advance beats into a pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_beat): a beat with cmd
//   CMD_START loads two endpoints and yields the first pixel; a beat with
//   cmd CMD_ADVANCE yields the next pixel, or nothing when no line is live.
//   Output channel (o_out_valid / i_out_stall / o_out_beat): one pixel beat
//   per producing input beat, in draw_color, last_pixel set on the final one.
//   APB port: draw_color at byte address 0, write it only while idle.
//   Path: a pixel passes the input register, then the result register,
//   before it is offered. Throughput is one beat per cycle while
//   i_out_stall stays low, as the error update and minor step of the
//   loop are combinational.
//   Stall: while a pixel waits under i_out_stall one more input beat is
//   held in the input register; then o_in_stall rises.
//   Reset: no line active, draw_color = 0xFFFF, both channels empty.
// ----------------------------------------------------------------------------
module line_pixel_generator_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  lpg_pkg::t_in_beat                    i_in_beat,
    // output channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output lpg_pkg::t_out_beat                   o_out_beat,
    // configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lpg_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  logic [lpg_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic [lpg_pkg::APB_DATA_BITS-1:0]    prdata,
    output logic                                 pready
);

    logic                  r_in_valid, r_out_valid;
    logic                  r_cmd;
    lpg_pkg::t_line        r_line;
    lpg_pkg::t_out_beat    r_out_beat;
    lpg_pkg::t_color       r_draw_color;

    lpg_pkg::t_line        setup_line;
    lpg_pkg::t_out_beat    step_pixel;
    lpg_pkg::t_step_status step_status;
    logic                  out_free, fire, in_accept, reg_index, cfg_write;

    // start beat normalisation
    lpg_setup u_setup (
        .i_beat (i_in_beat),
        .o_line (setup_line)
    );

    // handshake control
    always_comb begin
        out_free   = !r_out_valid || !i_out_stall;
        fire       = r_in_valid && out_free;
        o_in_stall = r_in_valid && !out_free;
        in_accept  = i_in_valid && !o_in_stall;
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd  <= i_in_beat.cmd;
            r_line <= setup_line;
        end
    end

    // stepping stage
    lpg_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_cmd    (r_cmd),
        .i_line   (r_line),
        .i_color  (r_draw_color),
        .o_pixel  (step_pixel),
        .o_status (step_status)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= step_status.produce;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && step_status.produce) begin
            r_out_beat <= step_pixel;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    // configuration register
    always_comb begin
        reg_index = paddr[lpg_pkg::APB_ADDR_BITS-1];
        cfg_write = psel && penable && pwrite && pready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_draw_color <= lpg_pkg::DRAW_COLOR_RESET;
        end else if (cfg_write && reg_index == lpg_pkg::REG_DRAW_COLOR) begin
            r_draw_color <= pwdata[lpg_pkg::COLOR_BITS-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (reg_index == lpg_pkg::REG_DRAW_COLOR)
                  ? lpg_pkg::APB_DATA_BITS'(r_draw_color) : '0;

    // checks
    a_start_gives_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_cmd == lpg_pkg::CMD_START |=> r_out_valid)
        else $error("start beat produced no pixel");

    a_idle_advance_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_cmd == lpg_pkg::CMD_ADVANCE && !step_status.busy |=> !r_out_valid)
        else $error("advance with no live line produced a pixel");

    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && step_status.produce && step_pixel.last_pixel |=> !step_status.busy)
        else $error("line still live after its last pixel");

    a_more_keeps_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && step_status.produce && !step_pixel.last_pixel |=> step_status.busy)
        else $error("line dropped before its last pixel");

endmodule
